// ===== src/apu_frame_sequencer_status_macros.svh =====
// ----------------------------------------------------------------------------
// Frame sequencer assertion macros
// Concurrent check helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef APU_FRAME_SEQUENCER_STATUS_MACROS_SVH
`define APU_FRAME_SEQUENCER_STATUS_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define AFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define AFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define AFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/afs_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame sequencer package
// Word types, register codes and the step function shared by the modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package afs_pkg;

	localparam logic [1:0]  KIND_TICK  = 2'd0;
	localparam logic [1:0]  KIND_WRITE = 2'd1;
	localparam logic [1:0]  KIND_READ  = 2'd2;

	localparam logic [4:0]  ADDR_STATUS = 5'h15;
	localparam logic [4:0]  ADDR_FRAME  = 5'h17;

	localparam logic [7:0]  FRAME_IRQ_CLEAR_READ = 8'h40;

	localparam logic [11:0] STARTUP_HOLD_CYCLES = 12'd2048;
	localparam logic [15:0] FRAME_PERIOD_RESET  = 16'd14915;
	localparam logic [2:0]  STEP_RESET          = 3'd4;
	localparam logic [2:0]  STEPS_FOUR          = 3'd4;
	localparam logic [2:0]  STEPS_FIVE          = 3'd5;

	localparam int          PADDR_W   = 3;
	localparam logic        REG_FRAME_PERIOD = 1'b0;

	typedef struct packed {
		logic [1:0] kind;
		logic [4:0] reg_address;
		logic [7:0] write_data;
		logic [7:0] cycle_count;
		logic [4:0] length_active;
		logic       dmc_irq_flag;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] channel_cycles;
		logic       quarter_strobe;
		logic       half_strobe;
		logic       enable_write;
		logic [4:0] enable_bits;
		logic       dmc_irq_clear;
		logic       irq_line;
	} result_t;

	typedef struct packed {
		logic [2:0] idx;
		logic       quarter;
		logic       half;
		logic       set_pending;
	} step_t;

	function automatic step_t seq_step(input logic [2:0] cur, input logic five);
		step_t      s;
		logic [2:0] limit;
		logic [2:0] nxt;
		limit = five ? STEPS_FIVE : STEPS_FOUR;
		nxt   = cur + 3'd1;
		if (nxt >= limit) begin
			nxt = 3'd0;
		end
		s.idx         = nxt;
		s.half        = (nxt == 3'd1) || (nxt == 3'd3);
		s.quarter     = (nxt < 3'd4);
		s.set_pending = (nxt == 3'd3) && !five;
		return s;
	endfunction

endpackage

// ===== src/afs_cfg.sv =====
// ----------------------------------------------------------------------------
// Frame sequencer configuration port
// APB register holding the frame period.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afs_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [afs_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic [15:0]                 frame_period
);
	import afs_pkg::*;

	logic [15:0] frame_period_q;
	logic        sel_period;

	assign sel_period   = (paddr[PADDR_W-1] == REG_FRAME_PERIOD);
	assign pready       = 1'b1;
	assign frame_period = frame_period_q;
	assign prdata       = sel_period ? {16'd0, frame_period_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_period_q <= FRAME_PERIOD_RESET;
		end else if (psel && penable && pwrite && pready && sel_period) begin
			frame_period_q <= pwdata[15:0];
		end
	end

endmodule

// ===== src/afs_core.sv =====
// ----------------------------------------------------------------------------
// Frame sequencer core
// Sequencer state and the single-pass update for one word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "apu_frame_sequencer_status_macros.svh"

module afs_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  afs_pkg::item_t   item,
	input  logic [15:0]      frame_period,
	output afs_pkg::result_t result
);
	import afs_pkg::*;

	logic [16:0] master_q,    master_d;
	logic [2:0]  step_q,      step_d;
	logic        five_q,      five_d;
	logic        irq_en_q,    irq_en_d;
	logic        pend_q,      pend_d;
	logic [11:0] remain_q,    remain_d;
	logic        hold_q,      hold_d;
	logic        irq_q,       irq_d;

	logic [16:0] sum;
	step_t       st;
	result_t     res;

	always_comb begin
		master_d = master_q;
		step_d   = step_q;
		five_d   = five_q;
		irq_en_d = irq_en_q;
		pend_d   = pend_q;
		remain_d = remain_q;
		hold_d   = hold_q;
		irq_d    = irq_q;
		res      = '0;
		sum      = master_q + {8'd0, item.cycle_count, 1'b0};
		st       = seq_step(step_q, five_q);
		case (item.kind)
			KIND_TICK: begin
				if (hold_q && (remain_q != 12'd0)) begin
					if ({4'd0, item.cycle_count} >= remain_q) begin
						remain_d = 12'd0;
						hold_d   = 1'b0;
					end else begin
						remain_d = remain_q - {4'd0, item.cycle_count};
					end
				end else if (item.cycle_count != 8'd0) begin
					res.channel_cycles = item.cycle_count;
					irq_d = (irq_en_q && pend_q) || item.dmc_irq_flag;
					if (sum >= {1'b0, frame_period}) begin
						master_d           = sum - {1'b0, frame_period};
						step_d             = st.idx;
						res.quarter_strobe = st.quarter;
						res.half_strobe    = st.half;
						if (st.set_pending) begin
							pend_d = 1'b1;
						end
					end else begin
						master_d = sum;
					end
				end
			end
			KIND_WRITE: begin
				if (item.reg_address == ADDR_STATUS) begin
					res.enable_write = 1'b1;
					res.enable_bits  = item.write_data[4:0];
					if ((item.write_data != 8'd0) && (remain_q != 12'd0)) begin
						hold_d = 1'b1;
					end
				end else if (item.reg_address == ADDR_FRAME) begin
					five_d   = item.write_data[7];
					master_d = 17'd0;
					pend_d   = 1'b0;
					irq_en_d = !item.write_data[6];
					if (!item.write_data[7]) begin
						step_d = STEP_RESET;
					end else begin
						st                 = seq_step(3'd0, 1'b1);
						step_d             = st.idx;
						res.quarter_strobe = st.quarter;
						res.half_strobe    = st.half;
					end
				end
			end
			KIND_READ: begin
				if (item.reg_address == ADDR_STATUS) begin
					res.read_data     = {item.dmc_irq_flag, pend_q && irq_en_q, 1'b0,
						item.length_active};
					pend_d            = 1'b0;
					res.dmc_irq_clear = 1'b1;
					irq_d             = 1'b0;
				end else if (item.reg_address == ADDR_FRAME) begin
					res.read_data = pend_q ? 8'd0 : FRAME_IRQ_CLEAR_READ;
				end
			end
			default: begin
			end
		endcase
		res.irq_line = irq_d;
	end

	assign result = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q <= 17'd0;
			step_q   <= STEP_RESET;
			five_q   <= 1'b0;
			irq_en_q <= 1'b0;
			pend_q   <= 1'b0;
			remain_q <= STARTUP_HOLD_CYCLES;
			hold_q   <= 1'b0;
			irq_q    <= 1'b0;
		end else if (fire) begin
			master_q <= master_d;
			step_q   <= step_d;
			five_q   <= five_d;
			irq_en_q <= irq_en_d;
			pend_q   <= pend_d;
			remain_q <= remain_d;
			hold_q   <= hold_d;
			irq_q    <= irq_d;
		end
	end

	`AFS_ASSERT_NOW(a_hold_has_budget, clk, arst_n, hold_q, remain_q != 12'd0, "hold with no budget")
	`AFS_ASSERT_NOW(a_hold_swallows, clk, arst_n, fire && hold_q && (item.kind == KIND_TICK), res.channel_cycles == 8'd0, "tick passed during hold")
	`AFS_ASSERT_NEXT(a_status_read_clears, clk, arst_n, fire && (item.kind == KIND_READ) && (item.reg_address == ADDR_STATUS), !irq_q && !pend_q, "status read left irq set")
	`AFS_ASSERT_NOW(a_five_no_frame_irq, clk, arst_n, five_q, !pend_q, "frame irq pending in 5-step mode")

endmodule

// ===== src/apu_frame_sequencer_status.sv =====
// ----------------------------------------------------------------------------
// Audio frame sequencer with status and interrupt
// Takes one word per cycle while the output is not stalled: an input register
// feeds the core, whose result is held in an output register. Sustained rate is
// one word per clock under that condition. All state updates for a word happen
// in the single cycle it moves from the input register into the output
// register, so throughput is bounded only by the output handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apu_frame_sequencer_status (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  afs_pkg::item_t              item,
	output logic                        result_valid,
	input  logic                        result_ready,
	output afs_pkg::result_t            result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [afs_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import afs_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    res_valid_s2;
	result_t res_s2;
	result_t core_res;
	logic    advance;
	logic    fire;
	logic [15:0] frame_period;

	assign advance      = !res_valid_s2 || result_ready;
	assign item_ready   = !valid_s1 || advance;
	assign fire         = valid_s1 && advance;
	assign result_valid = res_valid_s2;
	assign result       = res_s2;

	afs_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.frame_period (frame_period)
	);

	afs_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.item         (item_s1),
		.frame_period (frame_period),
		.result       (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			res_valid_s2 <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				res_valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (fire) begin
			res_s2 <= core_res;
		end
	end

endmodule
